>>> rtl/core/dac_waveform_command_sequencer_defines.svh
// Assertion helpers for the DAC waveform command sequencer.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef DAC_WAVEFORM_COMMAND_SEQUENCER_DEFINES_SVH
`define DAC_WAVEFORM_COMMAND_SEQUENCER_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define DWCS_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define DWCS_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dwcs_pkg.sv
// ----------------------------------------------------------------------------
// dwcs_pkg
// Types, widths and codes shared by the waveform command sequencer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dwcs_pkg;

  localparam int CLK_HZ_W   = 28;
  localparam int ACT_W      = 3;
  localparam int FUNC_W     = 2;
  localparam int TIME_W     = 32;
  localparam int CODES_W    = 64;
  localparam int SLOT_W     = 16;
  localparam int LANES      = 4;
  localparam int CYC_W      = 32;
  localparam int KIND_W     = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int DEF_CHANNELS   = 4;
  localparam int DEF_CODE_WIDTH = 16;

  localparam int CLK_HZ_RST = 50000000;
  localparam int ACT_RST    = 4;

  // Cycle conversion: floor((t * hz + 32768000) / 65536000), split as a
  // shift by 2^16 followed by a division by 1000.
  localparam int ROUND_HALF = 32768000;
  localparam int SHIFT      = 16;
  localparam int DIV_K      = 1000;
  localparam int PROD_W     = TIME_W + CLK_HZ_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int V_W        = SUM_W - SHIFT;
  localparam int HI_W       = V_W - CYC_W;
  localparam int REM_W      = 10;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STGS   = CYC_W / DIV_STEPS;

  localparam int Q_DEPTH    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOCK_HZ = 2'd0,
    REG_ACTIVE   = 2'd1
  } reg_idx_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_DATA  = 2'd0,
    FUNC_FLUSH = 2'd1,
    FUNC_ABORT = 2'd2
  } func_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NOOP    = 2'd0,
    KIND_ON_TRIG = 2'd1,
    KIND_DELAY   = 2'd2
  } cmd_kind_t;

  // One classified word handed from the front end to the back end.
  typedef struct packed {
    func_t              func;
    logic               noop;
    logic               on_trig;
    logic [CYC_W-1:0]   delay;
    logic [CODES_W-1:0] codes;
  } q_entry_t;

endpackage : dwcs_pkg

`default_nettype wire

>>> rtl/core/dwcs_front.sv
// ----------------------------------------------------------------------------
// dwcs_front
// Accepts input words, masks lanes, converts timestamps to clock counts in a
// pipeline and classifies each row into a command entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dwcs_front #(
  parameter int CHANNELS   = dwcs_pkg::DEF_CHANNELS,
  parameter int CODE_WIDTH = dwcs_pkg::DEF_CODE_WIDTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [dwcs_pkg::CLK_HZ_W-1:0]  clock_hz,
  input  wire logic [dwcs_pkg::ACT_W-1:0]     active_channels,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [dwcs_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [dwcs_pkg::TIME_W-1:0]    in_row_time,
  input  wire logic [dwcs_pkg::CODES_W-1:0]   in_channel_codes,
  output logic                                q_valid,
  input  wire logic                           q_ready,
  output dwcs_pkg::q_entry_t                  q_entry
);
  import dwcs_pkg::*;

  typedef struct packed {
    func_t              func;
    logic               trig;
    logic [CODES_W-1:0] codes;
  } fe_item_t;

  typedef struct packed {
    fe_item_t           item;
    logic               sat;
    logic [REM_W-1:0]   rem;
    logic [CYC_W-1:0]   work;
  } div_stg_t;

  logic                en;
  logic                acc;

  logic                seen_r, seen_nxt;
  logic [TIME_W-1:0]   last_time_r, last_time_nxt;
  logic [CYC_W-1:0]    last_cyc_r, last_cyc_nxt;

  logic                vld0_r, vld0_nxt;
  fe_item_t            item0_r, item0_nxt;
  logic [TIME_W-1:0]   time0_r;

  logic                vld1_r, vld1_nxt;
  fe_item_t            item1_r;
  logic [PROD_W-1:0]   prod1_r, prod1_nxt;

  logic [DIV_STGS:0]   dvld_r, dvld_nxt;
  div_stg_t            dstg_r   [DIV_STGS+1];
  div_stg_t            dstg_nxt [DIV_STGS+1];

  logic [ACT_W-1:0]    act_n;
  logic [CODES_W-1:0]  codes_f;
  logic [SUM_W-1:0]    sum2;
  logic [V_W-1:0]      v2;
  logic [CYC_W-1:0]    clks;
  logic                push;

  assign en       = !dvld_r[DIV_STGS] || q_ready;
  assign in_ready = en;
  assign acc      = in_valid && en;

  // Lane masking, and reduction of each code to CODE_WIDTH bits sign-extended to its slot.
  always_comb begin
    logic [CODE_WIDTH-1:0] lane;
    act_n   = (active_channels > ACT_W'(CHANNELS)) ? ACT_W'(CHANNELS) : active_channels;
    codes_f = '0;
    for (int i = 0; i < LANES; i++) begin
      lane = in_channel_codes[SLOT_W*i +: CODE_WIDTH];
      if (ACT_W'(i) < act_n) begin
        codes_f[SLOT_W*i +: SLOT_W] = SLOT_W'(signed'(lane));
      end
    end
  end

  // Entry stage and trigger tracking.
  always_comb begin
    seen_nxt       = seen_r;
    last_time_nxt  = last_time_r;
    vld0_nxt       = en ? 1'b0 : vld0_r;
    item0_nxt      = item0_r;
    item0_nxt.func = func_t'(in_func);
    item0_nxt.trig = !seen_r || (in_row_time < last_time_r);
    item0_nxt.codes = codes_f;
    if (acc) begin
      case (in_func)
        FUNC_DATA: begin
          vld0_nxt      = 1'b1;
          seen_nxt      = 1'b1;
          last_time_nxt = in_row_time;
        end
        FUNC_FLUSH, FUNC_ABORT: begin
          vld0_nxt = 1'b1;
          seen_nxt = 1'b0;
        end
        default: begin
          vld0_nxt = 1'b0;
        end
      endcase
    end
  end

  assign vld1_nxt  = en ? vld0_r : vld1_r;
  assign prod1_nxt = PROD_W'(time0_r) * PROD_W'(clock_hz);

  // Rounding offset, shift by 2^16 and saturation check.
  assign sum2 = SUM_W'(prod1_r) + SUM_W'(ROUND_HALF);
  assign v2   = sum2[SUM_W-1:SHIFT];

  always_comb begin
    logic [REM_W:0] r;
    dstg_nxt[0].item = item1_r;
    dstg_nxt[0].sat  = v2[V_W-1:CYC_W] >= HI_W'(DIV_K);
    dstg_nxt[0].rem  = v2[CYC_W+REM_W-1:CYC_W];
    dstg_nxt[0].work = v2[CYC_W-1:0];
    // Restoring division by 1000, four quotient bits per stage.
    for (int k = 0; k < DIV_STGS; k++) begin
      dstg_nxt[k+1] = dstg_r[k];
      for (int j = 0; j < DIV_STEPS; j++) begin
        r = {dstg_nxt[k+1].rem, dstg_nxt[k+1].work[CYC_W-1]};
        if (r >= (REM_W+1)'(DIV_K)) begin
          dstg_nxt[k+1].rem  = REM_W'(r - (REM_W+1)'(DIV_K));
          dstg_nxt[k+1].work = {dstg_nxt[k+1].work[CYC_W-2:0], 1'b1};
        end else begin
          dstg_nxt[k+1].rem  = r[REM_W-1:0];
          dstg_nxt[k+1].work = {dstg_nxt[k+1].work[CYC_W-2:0], 1'b0};
        end
      end
    end
    dvld_nxt = en ? {dvld_r[DIV_STGS-1:0], vld1_r} : dvld_r;
  end

  // Classification at the tail of the pipeline.
  assign clks = dstg_r[DIV_STGS].sat ? '1 : dstg_r[DIV_STGS].work;

  always_comb begin
    q_entry.func  = dstg_r[DIV_STGS].item.func;
    q_entry.codes = dstg_r[DIV_STGS].item.codes;
    if (dstg_r[DIV_STGS].item.trig) begin
      if (clks == '0) begin
        q_entry.noop    = 1'b0;
        q_entry.on_trig = 1'b1;
        q_entry.delay   = '0;
      end else begin
        q_entry.noop    = 1'b1;
        q_entry.on_trig = 1'b0;
        q_entry.delay   = clks;
      end
    end else begin
      q_entry.noop    = 1'b0;
      q_entry.on_trig = 1'b0;
      q_entry.delay   = clks - last_cyc_r;
    end
  end

  assign q_valid      = dvld_r[DIV_STGS];
  assign push         = q_valid && q_ready;
  assign last_cyc_nxt = (push && dstg_r[DIV_STGS].item.func == FUNC_DATA) ? clks : last_cyc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= 1'b0;
      last_time_r <= '0;
      last_cyc_r  <= '0;
      vld0_r      <= 1'b0;
      vld1_r      <= 1'b0;
      dvld_r      <= '0;
    end else begin
      seen_r      <= seen_nxt;
      last_time_r <= last_time_nxt;
      last_cyc_r  <= last_cyc_nxt;
      vld0_r      <= vld0_nxt;
      vld1_r      <= vld1_nxt;
      dvld_r      <= dvld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (acc) begin
        item0_r <= item0_nxt;
        time0_r <= in_row_time;
      end
      item1_r <= item0_r;
      prod1_r <= prod1_nxt;
      for (int k = 0; k <= DIV_STGS; k++) begin
        dstg_r[k] <= dstg_nxt[k];
      end
    end
  end

endmodule : dwcs_front

`default_nettype wire

>>> rtl/core/dwcs_queue.sv
// ----------------------------------------------------------------------------
// dwcs_queue
// Short first-in first-out buffer of command entries between the two halves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dwcs_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  wire dwcs_pkg::q_entry_t push_entry,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output dwcs_pkg::q_entry_t      pop_entry
);
  import dwcs_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  q_entry_t          mem_r [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = cnt_r != CNT_W'(Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_entry  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule : dwcs_queue

`default_nettype wire

>>> rtl/core/dwcs_back.sv
// ----------------------------------------------------------------------------
// dwcs_back
// Holds the pending command and releases it, with its trigger-wait no-op,
// when the next data or flush entry arrives; an abort discards it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dwcs_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  output logic                               q_pop,
  input  wire dwcs_pkg::q_entry_t            q_entry,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [dwcs_pkg::KIND_W-1:0]        out_cmd_kind,
  output logic [dwcs_pkg::CYC_W-1:0]         out_delay_cycles,
  output logic [dwcs_pkg::CODES_W-1:0]       out_codes,
  output logic                               out_final_cmd
);
  import dwcs_pkg::*;

  logic                pend_valid_r, pend_valid_nxt;
  logic                pend_noop_r;
  logic                pend_on_trig_r;
  logic [CYC_W-1:0]    pend_delay_r;
  logic [CODES_W-1:0]  pend_codes_r;
  logic                noop_sent_r, noop_sent_nxt;

  logic                out_valid_r, out_valid_nxt;
  cmd_kind_t           out_kind_r, out_kind_nxt;
  logic [CYC_W-1:0]    out_delay_r, out_delay_nxt;
  logic [CODES_W-1:0]  out_codes_r, out_codes_nxt;
  logic                out_final_r, out_final_nxt;

  logic                is_rel_func;
  logic                rel;
  logic                emit_noop;
  logic                emit_apply;
  logic                can;
  logic                load;

  assign is_rel_func = (q_entry.func == FUNC_DATA) || (q_entry.func == FUNC_FLUSH);
  assign rel         = q_valid && is_rel_func && pend_valid_r;
  assign emit_noop   = rel && pend_noop_r && !noop_sent_r;
  assign emit_apply  = rel && !emit_noop;
  assign can         = !out_valid_r || out_ready;
  assign load        = (emit_noop || emit_apply) && can;
  assign q_pop       = q_valid && (!rel || (emit_apply && can));

  always_comb begin
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_delay_nxt = out_delay_r;
    out_codes_nxt = out_codes_r;
    out_final_nxt = out_final_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (emit_noop) begin
        out_kind_nxt  = KIND_NOOP;
        out_delay_nxt = '0;
        out_codes_nxt = '0;
        out_final_nxt = 1'b0;
      end else begin
        out_kind_nxt  = pend_on_trig_r ? KIND_ON_TRIG : KIND_DELAY;
        out_delay_nxt = pend_on_trig_r ? '0 : pend_delay_r;
        out_codes_nxt = pend_codes_r;
        out_final_nxt = q_entry.func == FUNC_FLUSH;
      end
    end
  end

  always_comb begin
    noop_sent_nxt  = noop_sent_r;
    pend_valid_nxt = pend_valid_r;
    if (q_pop) begin
      noop_sent_nxt  = 1'b0;
      pend_valid_nxt = q_entry.func == FUNC_DATA;
    end else if (emit_noop && can) begin
      noop_sent_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      noop_sent_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      noop_sent_r  <= noop_sent_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pend_noop_r    <= q_entry.noop;
      pend_on_trig_r <= q_entry.on_trig;
      pend_delay_r   <= q_entry.delay;
      pend_codes_r   <= q_entry.codes;
    end
    out_kind_r  <= out_kind_nxt;
    out_delay_r <= out_delay_nxt;
    out_codes_r <= out_codes_nxt;
    out_final_r <= out_final_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_cmd_kind     = out_kind_r;
  assign out_delay_cycles = out_delay_r;
  assign out_codes        = out_codes_r;
  assign out_final_cmd    = out_final_r;

endmodule : dwcs_back

`default_nettype wire

>>> rtl/core/dac_waveform_command_sequencer.sv
// ----------------------------------------------------------------------------
// dac_waveform_command_sequencer
// Turns timestamped waveform rows into DAC trigger-wait, apply-on-trigger and
// apply-after-delay commands.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_*) takes one word per cycle while in_ready is high:
// a data row, an end of stream flush or an abort. The result channel (out_*)
// delivers command words with valid and ready. The configuration channel
// (cfg_*) writes clock_hz (index 0) and active_channels (index 1); it is
// always ready and must only be used while the block is idle.
// A row's command is held back until the next input word arrives, because
// that word decides whether the command is the final one. Once that next
// word is accepted, it passes through 11 pipeline stages for the millisecond
// to cycle conversion (input, multiply, round, eight divider stages), then
// through the entry queue and the output register.
// Throughput is one input word per cycle while nothing stalls; the output
// register delivers one result per cycle while out_ready is high, so a
// trigger row that releases a no-op and an apply command holds the output
// for both results in turn.
// When the receiver stalls, the output register holds its word, the queue
// fills and the pipeline and in_ready stall behind it; nothing is dropped.
// Reset clears all pending commands and trigger tracking and restores the
// registers to 50 MHz and four channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dac_waveform_command_sequencer #(
  parameter int CHANNELS   = dwcs_pkg::DEF_CHANNELS,
  parameter int CODE_WIDTH = dwcs_pkg::DEF_CODE_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [dwcs_pkg::FUNC_W-1:0]      in_func,
  input  wire logic [dwcs_pkg::TIME_W-1:0]      in_row_time,
  input  wire logic [dwcs_pkg::CODES_W-1:0]     in_channel_codes,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [dwcs_pkg::KIND_W-1:0]           out_cmd_kind,
  output logic [dwcs_pkg::CYC_W-1:0]            out_delay_cycles,
  output logic [dwcs_pkg::CODES_W-1:0]          out_codes,
  output logic                                  out_final_cmd,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [dwcs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dwcs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import dwcs_pkg::*;

  logic [CLK_HZ_W-1:0] clock_hz_r, clock_hz_nxt;
  logic [ACT_W-1:0]    act_r, act_nxt;

  // Front to queue.
  logic                fq_valid;
  logic                fq_ready;
  q_entry_t            fq_entry;

  // Queue to back.
  logic                qb_valid;
  logic                qb_pop;
  q_entry_t            qb_entry;

  // Configuration writes land in the next cycle; writes to unknown indexes
  // are accepted and ignored.
  assign cfg_ready = 1'b1;

  always_comb begin
    clock_hz_nxt = clock_hz_r;
    act_nxt      = act_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_CLOCK_HZ: clock_hz_nxt = cfg_wdata[CLK_HZ_W-1:0];
        REG_ACTIVE:   act_nxt      = cfg_wdata[ACT_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= CLK_HZ_W'(CLK_HZ_RST);
      act_r      <= ACT_W'(ACT_RST);
    end else begin
      clock_hz_r <= clock_hz_nxt;
      act_r      <= act_nxt;
    end
  end

  // Front end: accept, mask lanes, convert time and classify each row.
  dwcs_front #(
    .CHANNELS   (CHANNELS),
    .CODE_WIDTH (CODE_WIDTH)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .clock_hz         (clock_hz_r),
    .active_channels  (act_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_row_time      (in_row_time),
    .in_channel_codes (in_channel_codes),
    .q_valid          (fq_valid),
    .q_ready          (fq_ready),
    .q_entry          (fq_entry)
  );

  // The queue lets the back end pause on a two-result row while the front
  // keeps taking words.
  dwcs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_entry (fq_entry),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_pop),
    .pop_entry  (qb_entry)
  );

  // Back end: pending command and result sequencing.
  dwcs_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (qb_valid),
    .q_pop            (qb_pop),
    .q_entry          (qb_entry),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_cmd_kind     (out_cmd_kind),
    .out_delay_cycles (out_delay_cycles),
    .out_codes        (out_codes),
    .out_final_cmd    (out_final_cmd)
  );

endmodule : dac_waveform_command_sequencer

`default_nettype wire

>>> rtl/core/dwcs_checker.sv
// ----------------------------------------------------------------------------
// dwcs_checker
// Port-level checks on the command words of the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "dac_waveform_command_sequencer_defines.svh"

module dwcs_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic [dwcs_pkg::KIND_W-1:0]   out_cmd_kind,
  input wire logic [dwcs_pkg::CYC_W-1:0]    out_delay_cycles,
  input wire logic [dwcs_pkg::CODES_W-1:0]  out_codes,
  input wire logic                          out_final_cmd
);
  import dwcs_pkg::*;

  // A stalled word stays put.
  `DWCS_AST_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_cmd_kind) && $stable(out_delay_cycles) && $stable(out_codes) && $stable(out_final_cmd), "stalled word changed")

  // A no-op carries no delay, no codes and is never final.
  `DWCS_AST_IMP(a_noop_clean, out_valid && out_cmd_kind == KIND_NOOP, out_delay_cycles == '0 && out_codes == '0 && !out_final_cmd, "no-op carries data")

  // Apply on trigger has no delay.
  `DWCS_AST_IMP(a_trig_nodelay, out_valid && out_cmd_kind == KIND_ON_TRIG, out_delay_cycles == '0, "apply on trigger with delay")

  // The apply command follows its no-op straight away.
  `DWCS_AST_NXT(a_noop_then_apply, out_valid && out_ready && out_cmd_kind == KIND_NOOP, out_valid && out_cmd_kind != KIND_NOOP, "no-op not followed by apply")

endmodule : dwcs_checker

bind dac_waveform_command_sequencer dwcs_checker u_dwcs_checker (.*);

`default_nettype wire
